/* design/brb_pkg.sv */
// Shared types and constants for the byte ring buffer with peek and drop.
// Holds the transaction structs, the command codes, the queued command format and default sizes.
// No dependencies.
`default_nettype none

package brb_pkg;

   localparam int OP_W     = 3;
   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 13;
   localparam int OFFSET_W = 12;

   localparam int DEPTH_DEFAULT   = 4096;
   localparam int MAX_RUN_DEFAULT = 64;
   localparam int QUEUE_DEPTH     = 4;

   // Command codes carried in the op field. The codes above OP_DROP_NEWEST are unused.
   typedef enum logic [OP_W-1:0] {
      OP_WRITE,
      OP_READ,
      OP_PEEK,
      OP_DROP_OLDEST,
      OP_DROP_NEWEST,
      OP_RSVD5,
      OP_RSVD6,
      OP_RSVD7
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [BYTE_W-1:0]   data_in;
      logic [COUNT_W-1:0]  count;
      logic [OFFSET_W-1:0] offset;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  data_out;
      logic               byte_valid;
      logic [COUNT_W-1:0] done_count;
      logic               last;
      logic [COUNT_W-1:0] fill_level;
   } rsp_type;

   // What the back end has to do for one command.
   typedef enum logic [1:0] {
      CMD_SINGLE,
      CMD_WRITE,
      CMD_RUN
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [BYTE_W-1:0]  data;
      logic [COUNT_W-1:0] done_count;
      logic [COUNT_W-1:0] fill_level;
   } cmd_type;

endpackage

`default_nettype wire

/* design/brb_front.sv */
// Front end: accepts transactions, owns head, fill level and ring size,
// and turns each transaction into one queued command. Uses brb_pkg.
`default_nettype none

module brb_front
   import brb_pkg::*;
#(
   parameter int DEPTH   = DEPTH_DEFAULT,
   parameter int MAX_RUN = MAX_RUN_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire req_type                    req_data,
   input  wire logic                       csr_wen,
   input  wire logic [COUNT_W-1:0]         csr_wdata,
   output logic                            cmd_valid,
   input  wire logic                       cmd_ready,
   output cmd_type                         cmd,
   output logic [$clog2(DEPTH)-1:0]        cmd_addr,
   output logic [$clog2(DEPTH)-1:0]        ring_last
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   logic [CNT_W-1:0] size_ff, size_in;
   logic [AW-1:0]    head_ff, head_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   logic [CW-1:0] fill_w, size_w, count_w, start_w, avail_w, run_n_w, drop_n_w, amt_w;
   logic [CW:0]   sum_x, wrap_x;
   logic [AW-1:0] wrap_addr;
   logic          accept;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign accept    = req_valid && req_ready;
   assign ring_last = AW'(size_ff - CNT_W'(1));

   // Ring size is clamped once, when it is written.
   always_comb begin
      if (csr_wdata == '0) begin
         size_in = CNT_W'(1);
      end else if (CW'(csr_wdata) > CW'(DEPTH)) begin
         size_in = CNT_W'(DEPTH);
      end else begin
         size_in = CNT_W'(csr_wdata);
      end
   end

   always_comb begin
      fill_w  = CW'(fill_ff);
      size_w  = CW'(size_ff);
      count_w = CW'(req_data.count);
      start_w = (req_data.op == OP_PEEK) ? CW'(req_data.offset) : '0;
      avail_w = (start_w < fill_w) ? fill_w - start_w : '0;

      run_n_w = avail_w;
      if (count_w < run_n_w) begin
         run_n_w = count_w;
      end
      if (run_n_w > CW'(MAX_RUN)) begin
         run_n_w = CW'(MAX_RUN);
      end
      drop_n_w = (count_w < fill_w) ? count_w : fill_w;

      // One wrapping adder serves every position the command needs.
      case (req_data.op)
         OP_WRITE:       amt_w = fill_w;
         OP_PEEK:        amt_w = start_w;
         OP_READ:        amt_w = run_n_w;
         OP_DROP_OLDEST: amt_w = drop_n_w;
         default:        amt_w = '0;
      endcase
      sum_x     = {1'b0, CW'(head_ff)} + {1'b0, amt_w};
      wrap_x    = (sum_x >= {1'b0, size_w}) ? sum_x - {1'b0, size_w} : sum_x;
      wrap_addr = AW'(wrap_x);
   end

   always_comb begin
      head_in         = head_ff;
      fill_in         = fill_ff;
      cmd_addr        = head_ff;
      cmd.kind        = CMD_SINGLE;
      cmd.data        = req_data.data_in;
      cmd.done_count  = '0;
      unique case (req_data.op)
         OP_WRITE: begin
            if (fill_w < size_w) begin
               cmd.kind       = CMD_WRITE;
               cmd.done_count = COUNT_W'(1);
               cmd_addr       = wrap_addr;
               fill_in        = fill_ff + CNT_W'(1);
            end
         end
         OP_READ: begin
            cmd.done_count = COUNT_W'(run_n_w);
            cmd.kind       = (run_n_w != '0) ? CMD_RUN : CMD_SINGLE;
            head_in        = wrap_addr;
            fill_in        = CNT_W'(fill_w - run_n_w);
         end
         OP_PEEK: begin
            cmd.done_count = COUNT_W'(run_n_w);
            cmd.kind       = (run_n_w != '0) ? CMD_RUN : CMD_SINGLE;
            cmd_addr       = wrap_addr;
         end
         OP_DROP_OLDEST: begin
            cmd.done_count = COUNT_W'(drop_n_w);
            head_in        = wrap_addr;
            fill_in        = CNT_W'(fill_w - drop_n_w);
         end
         OP_DROP_NEWEST: begin
            cmd.done_count = COUNT_W'(drop_n_w);
            fill_in        = CNT_W'(fill_w - drop_n_w);
         end
         default: begin
         end
      endcase
      cmd.fill_level = COUNT_W'(fill_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= CNT_W'(DEPTH);
         head_ff <= '0;
         fill_ff <= '0;
      end else if (csr_wen) begin
         size_ff <= size_in;
         head_ff <= '0;
         fill_ff <= '0;
      end else if (accept) begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

/* design/brb_cmd_queue.sv */
// Short command queue between the front and back ends of the byte ring buffer.
// Generic width; depth from brb_pkg.
`default_nettype none

module brb_cmd_queue
   import brb_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [WIDTH-1:0]      out_data
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]      used_ff;
   logic             push, pop;

   assign in_ready  = (used_ff != (PW+1)'(QUEUE_DEPTH));
   assign out_valid = (used_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            used_ff <= used_ff + (PW+1)'(1);
         end else if (pop && !push) begin
            used_ff <= used_ff - (PW+1)'(1);
         end
      end
   end

endmodule

`default_nettype wire

/* design/brb_back.sv */
// Back end: holds the byte store, carries out queued commands and streams
// results through a read stage and an output register. Uses brb_pkg.
`default_nettype none

module brb_back
   import brb_pkg::*;
#(
   parameter int DEPTH   = DEPTH_DEFAULT,
   parameter int MAX_RUN = MAX_RUN_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     cmd_valid,
   output logic                          cmd_ready,
   input  wire cmd_type                  cmd,
   input  wire logic [$clog2(DEPTH)-1:0] cmd_addr,
   input  wire logic [$clog2(DEPTH)-1:0] ring_last,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_type                       rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int IW = $clog2(MAX_RUN + 1);

   logic [BYTE_W-1:0] byte_store_ff [DEPTH];
   logic [BYTE_W-1:0] mem_q_ff;
   logic              rd_vld_ff, rd_vld_in;
   rsp_type           rd_meta_ff, rd_meta_in;
   logic              out_vld_ff, out_vld_in;
   rsp_type           out_ff, out_in;
   logic [IW-1:0]     idx_ff;
   logic [AW-1:0]     addr_ff, rd_addr;

   logic out_free, rd_move, stage_free, issue, is_run, run_last;

   assign out_free   = !out_vld_ff || rsp_ready;
   assign rd_move    = rd_vld_ff && out_free;
   assign stage_free = !rd_vld_ff || rd_move;
   assign issue      = cmd_valid && stage_free;
   assign is_run     = (cmd.kind == CMD_RUN);
   assign rd_addr    = (idx_ff == '0) ? cmd_addr : addr_ff;
   assign run_last   = ((COUNT_W'(idx_ff) + COUNT_W'(1)) == cmd.done_count);
   assign cmd_ready  = issue && (!is_run || run_last);

   always_comb begin
      rd_meta_in.data_out   = '0;
      rd_meta_in.byte_valid = is_run;
      rd_meta_in.done_count = cmd.done_count;
      rd_meta_in.last       = !is_run || run_last;
      rd_meta_in.fill_level = cmd.fill_level;

      out_in          = rd_meta_ff;
      out_in.data_out = rd_meta_ff.byte_valid ? mem_q_ff : '0;

      rd_vld_in = issue ? 1'b1 : (rd_move ? 1'b0 : rd_vld_ff);
      out_vld_in = rd_move ? 1'b1 : (rsp_ready ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (issue && (cmd.kind == CMD_WRITE)) begin
         byte_store_ff[cmd_addr] <= cmd.data;
      end
      if (issue && is_run) begin
         mem_q_ff <= byte_store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_meta_ff <= rd_meta_in;
      end
      if (rd_move) begin
         out_ff <= out_in;
      end
      if (issue && is_run) begin
         addr_ff <= (rd_addr == ring_last) ? '0 : rd_addr + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
         if (issue && is_run) begin
            idx_ff <= run_last ? '0 : idx_ff + IW'(1);
         end
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

/* design/byte_ring_buffer_peek_drop.sv */
// Byte ring buffer with read, peek, drop-oldest and drop-newest commands.
// rsp_valid rises once its accepted transaction has passed through the command
// queue entry, then the store read stage, then the output register.
// Throughput: one transaction per cycle while the command queue has room; a read or peek
// run delivers one byte per cycle, set by the single store read port, while rsp_ready is high.
// Reset (synchronous, active high) empties the ring and sets the size to DEPTH;
// the byte store itself is not cleared and needs no clearing pass.
`default_nettype none

module byte_ring_buffer_peek_drop
   import brb_pkg::*;
#(
   parameter int DEPTH   = DEPTH_DEFAULT,
   parameter int MAX_RUN = MAX_RUN_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data,
   input  wire logic               csr_wen,
   input  wire logic [COUNT_W-1:0] csr_wdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int QW = AW + $bits(cmd_type);

   // The front end decides everything about a transaction at acceptance: how
   // many bytes it moves, where they sit, and the head and fill level it
   // leaves behind. Pointer state therefore runs ahead of the store, which is
   // safe because the back end carries commands out strictly in order.
   logic          f_valid, f_ready;
   cmd_type       f_cmd;
   logic [AW-1:0] f_addr;
   logic [AW-1:0] ring_last;

   // Queued commands, each with its start address in the top bits.
   logic [QW-1:0] q_in, q_out;
   logic          q_valid, q_ready;
   cmd_type       q_cmd;
   logic [AW-1:0] q_addr;

   brb_front #(
      .DEPTH   (DEPTH),
      .MAX_RUN (MAX_RUN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .cmd_valid (f_valid),
      .cmd_ready (f_ready),
      .cmd       (f_cmd),
      .cmd_addr  (f_addr),
      .ring_last (ring_last)
   );

   assign q_in = {f_addr, f_cmd};

   // A few entries of slack let short commands keep flowing while the back
   // end streams out a long read or peek run.
   brb_cmd_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (q_in),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_out)
   );

   assign q_addr = q_out[QW-1 -: AW];
   assign q_cmd  = cmd_type'(q_out[$bits(cmd_type)-1:0]);

   // The back end writes stored bytes, reads runs from the store one byte per
   // cycle and holds each result in an output register. A stalled result side
   // holds the back end, and the front stops taking new transactions once the
   // command queue is full.
   brb_back #(
      .DEPTH   (DEPTH),
      .MAX_RUN (MAX_RUN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd       (q_cmd),
      .cmd_addr  (q_addr),
      .ring_last (ring_last),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
